>>> rtl/core/bld_pkg.sv
// Shared types, constants and helpers for the pixel blend compositor.
// No dependencies; imported by every module of the block.
`default_nettype none
package bld_pkg;

  localparam logic [7:0]  FULL      = 8'd255;
  localparam logic [15:0] FULL_SQ   = 16'd65025;
  localparam logic [7:0]  OVL_SPLIT = 8'd128;
  localparam int DIV_STAGES = 6;
  localparam int DIV_STEPS  = 4;
  localparam int SIDE_DEPTH = 11;
  localparam int VLD_DEPTH  = 12;
  // floor(x / 130050) as (x * ALPHA_RECIP) >> ALPHA_SHIFT, exact for x < 2^26
  localparam logic [26:0] ALPHA_RECIP = 27'd67636241;
  localparam int ALPHA_SHIFT = 43;

  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_MULTIPLY = 4'd1,
    MODE_ADD      = 4'd2,
    MODE_BURN     = 4'd3,
    MODE_DODGE    = 4'd4,
    MODE_REFLECT  = 4'd5,
    MODE_GLOW     = 4'd6,
    MODE_OVERLAY  = 4'd7,
    MODE_DIFF     = 4'd8,
    MODE_NEGATE   = 4'd9,
    MODE_LIGHTEN  = 4'd10,
    MODE_DARKEN   = 4'd11,
    MODE_SCREEN   = 4'd12,
    MODE_XOR      = 4'd13
  } bld_mode_t;

  typedef enum logic {
    CFG_BLEND_MODE = 1'b0,
    CFG_OPACITY    = 1'b1
  } cfg_idx_t;

  // channel 0 red, 1 green, 2 blue, 3 alpha
  typedef struct packed {
    logic [3:0][7:0] base;
    logic [3:0][7:0] top;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic at_zero;
    logic top_pass;
  } side_t;

  function automatic logic [7:0] div255(input logic [17:0] x);
    logic [18:0] sum;
    logic [10:0] q;
    logic [18:0] p;
    sum = {1'b0, x} + {9'd0, x[17:8]} + 19'd1;
    q   = sum[18:8];
    p   = {q, 8'd0} - {8'd0, q};
    if (p > {1'b0, x}) begin
      q = q - 11'd1;
    end else if (({1'b0, x} - p) >= 19'd255) begin
      q = q + 11'd1;
    end
    return q[7:0];
  endfunction

  function automatic logic [7:0] round_q16(input logic [23:0] q);
    logic [24:0] s;
    s = {1'b0, q} + 25'd32768;
    return (s[24:16] > 9'd255) ? FULL : s[23:16];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pixel_blend_compositor.sv
// Top level of the pixel blend compositor: alpha weights, compositing, rounding.
// Depends on bld_pkg, bld_mode and bld_div.
//
//   channel  ports                          handshake
//   request  in_base_*, in_top_*           start & !busy
//   result   out_red/green/blue/alpha      out_valid, one cycle, no back-pressure
//   config   cfg_wr_en, cfg_index, cfg_wdata  cfg_wr_en
//
// One pixel per clock. A request passes the request stage, the weight stages with
// the mode unit beside them, the 24-bit quotient divider (six stages of four bits)
// and the output register. busy stays low: the pipeline never stops.
// Synchronous reset clears the valid bits and loads mode normal, opacity 255.
`default_nettype none
module pixel_blend_compositor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_base_red,
  input  wire logic [7:0] in_base_green,
  input  wire logic [7:0] in_base_blue,
  input  wire logic [7:0] in_base_alpha,
  input  wire logic [7:0] in_top_red,
  input  wire logic [7:0] in_top_green,
  input  wire logic [7:0] in_top_blue,
  input  wire logic [7:0] in_top_alpha,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);
  import bld_pkg::*;

  bld_mode_t  cfg_mode_r, mode_a_r;
  logic [7:0] cfg_opac_r, opac_a_r;
  pix_t       pix_a_r;
  logic [VLD_DEPTH-1:0] vld_r;
  side_t      side_r [SIDE_DEPTH];
  logic [15:0] at_b_r, at_c_r;
  logic [7:0]  ab_b_r;
  logic [23:0] wb_c_r, wt_c_r, wm_c_r, wb_d_r, wt_d_r, wm_d_r, n_d_r, n_e_r, n_f_r;
  logic [2:0][31:0] pb_e_r, pt_e_r, pm_e_r, p_f_r;
  logic [2:0][7:0]  m_d;
  logic [2:0][23:0] quo;
  logic [24:0] alpha_num;
  logic [51:0] alpha_prod;
  logic [7:0]  alpha_r [DIV_STAGES];
  logic        out_valid_r;
  logic [3:0][7:0] out_r, out_nxt;
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r  <= MODE_NORMAL;
      cfg_opac_r  <= FULL;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BLEND_MODE: cfg_mode_r <= bld_mode_t'(cfg_wdata[3:0]);
          CFG_OPACITY:    cfg_opac_r <= cfg_wdata;
        endcase
      end
      vld_r       <= {vld_r[VLD_DEPTH-2:0], accept};
      out_valid_r <= vld_r[VLD_DEPTH-1];
    end
  end

  // request stage
  always_ff @(posedge clk) begin
    pix_a_r.base <= {in_base_alpha, in_base_blue, in_base_green, in_base_red};
    pix_a_r.top  <= {in_top_alpha, in_top_blue, in_top_green, in_top_red};
    mode_a_r     <= cfg_mode_r;
    opac_a_r     <= cfg_opac_r;
  end

  for (genvar c = 0; c < 3; c++) begin : g_mode
    bld_mode u_mode (
      .clk    (clk),
      .f_i    (pix_a_r.base[c]),
      .s_i    (pix_a_r.top[c]),
      .mode_i (mode_a_r),
      .m_o    (m_d[c])
    );
  end

  logic [15:0] at_nxt;
  assign at_nxt = pix_a_r.top[3] * opac_a_r;

  always_ff @(posedge clk) begin
    at_b_r <= at_nxt;
    ab_b_r <= pix_a_r.base[3];
    side_r[0] <= '{pix: pix_a_r, at_zero: (at_nxt == 16'd0),
                   top_pass: (pix_a_r.base[3] == 8'd0) && (opac_a_r == FULL)};
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_r[k] <= side_r[k-1];
    end
    // weights
    at_c_r <= at_b_r;
    wb_c_r <= 24'((FULL_SQ - at_b_r) * ab_b_r);
    wt_c_r <= 24'((FULL - ab_b_r) * at_b_r);
    wm_c_r <= 24'(ab_b_r * at_b_r);
    // output alpha numerator
    n_d_r  <= ({at_c_r, 8'd0} - {8'd0, at_c_r}) + wb_c_r;
    wb_d_r <= wb_c_r;
    wt_d_r <= wt_c_r;
    wm_d_r <= wm_c_r;
    // weighted terms
    for (int c = 0; c < 3; c++) begin
      pb_e_r[c] <= 32'(wb_d_r * side_r[2].pix.base[c]);
      pt_e_r[c] <= 32'(wt_d_r * side_r[2].pix.top[c]);
      pm_e_r[c] <= 32'(wm_d_r * m_d[c]);
      p_f_r[c]  <= pb_e_r[c] + pt_e_r[c] + pm_e_r[c];
    end
    n_e_r <= n_d_r;
    n_f_r <= n_e_r;
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    bld_div u_div (
      .clk   (clk),
      .num_i (p_f_r[c]),
      .den_i (n_f_r),
      .quo_o (quo[c])
    );
  end

  // output alpha: round(N / 65025) = floor((2N + 65025) / 130050)
  assign alpha_num  = {n_f_r, 1'b0} + {9'd0, FULL_SQ};
  assign alpha_prod = alpha_num * ALPHA_RECIP;

  always_ff @(posedge clk) begin
    alpha_r[0] <= alpha_prod[ALPHA_SHIFT +: 8];
    for (int k = 1; k < DIV_STAGES; k++) begin
      alpha_r[k] <= alpha_r[k-1];
    end
  end

  always_comb begin
    priority if (side_r[SIDE_DEPTH-1].at_zero) begin
      out_nxt = side_r[SIDE_DEPTH-1].pix.base;
    end else if (side_r[SIDE_DEPTH-1].top_pass) begin
      out_nxt = side_r[SIDE_DEPTH-1].pix.top;
    end else begin
      for (int c = 0; c < 3; c++) begin
        out_nxt[c] = round_q16(quo[c]);
      end
      out_nxt[3] = alpha_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];
  assign out_alpha = out_r[3];

endmodule
`default_nettype wire

>>> rtl/core/bld_mode.sv
// Per-channel blend mode unit: three register stages, saturated mode colour.
// Depends on bld_pkg.
`default_nettype none
module bld_mode (
  input  wire logic             clk,
  input  wire logic [7:0]       f_i,
  input  wire logic [7:0]       s_i,
  input  wire bld_pkg::bld_mode_t mode_i,
  output logic [7:0]            m_o
);
  import bld_pkg::*;

  // stage 1
  bld_mode_t  mode1_r, mode2_r;
  logic [7:0] s1_r;
  logic [15:0] fs1_r, inv1_r, dnum1_r, dnum2_r;
  logic [7:0] dden1_r, dden2_r;
  logic       grd1_r, grd2_r;
  logic [7:0] gval1_r, gval2_r, simp1_r, simp2_r;
  logic [7:0] arith2_r;
  logic       sat2_r;
  logic [7:0] rem2_r;
  logic [3:0] qhi2_r;
  logic [7:0] m_r;

  logic [7:0]  fs_nxt_a, fs_nxt_b, if_v, is_v, simp_nxt, gval_nxt, dden_nxt;
  logic        grd_nxt;
  logic [8:0]  sum9;
  logic signed [9:0] neg_t;
  logic [9:0]  neg_abs;

  always_comb begin
    if_v     = FULL - f_i;
    is_v     = FULL - s_i;
    sum9     = {1'b0, f_i} + {1'b0, s_i};
    neg_t    = $signed({2'b00, FULL}) - $signed({2'b00, f_i}) - $signed({2'b00, s_i});
    neg_abs  = neg_t[9] ? 10'(-neg_t) : 10'(neg_t);
    unique case (mode_i)
      MODE_ADD:     simp_nxt = sum9[8] ? FULL : sum9[7:0];
      MODE_DIFF:    simp_nxt = (f_i > s_i) ? (f_i - s_i) : (s_i - f_i);
      MODE_NEGATE:  simp_nxt = FULL - neg_abs[7:0];
      MODE_LIGHTEN: simp_nxt = (f_i > s_i) ? f_i : s_i;
      MODE_DARKEN:  simp_nxt = (f_i < s_i) ? f_i : s_i;
      MODE_XOR:     simp_nxt = f_i ^ s_i;
      default:      simp_nxt = s_i;
    endcase
    fs_nxt_a = 8'd0;
    fs_nxt_b = 8'd0;
    dden_nxt = 8'd1;
    grd_nxt  = 1'b0;
    gval_nxt = 8'd0;
    unique case (mode_i)
      MODE_BURN: begin
        fs_nxt_a = if_v; fs_nxt_b = FULL; dden_nxt = s_i;
        grd_nxt  = (s_i == 8'd0); gval_nxt = 8'd0;
      end
      MODE_DODGE: begin
        fs_nxt_a = f_i; fs_nxt_b = FULL; dden_nxt = is_v;
        grd_nxt  = (s_i == FULL); gval_nxt = FULL;
      end
      MODE_REFLECT: begin
        fs_nxt_a = f_i; fs_nxt_b = f_i; dden_nxt = is_v;
        grd_nxt  = (s_i == 8'd0) || (s_i == FULL);
        gval_nxt = (s_i == 8'd0) ? f_i : FULL;
      end
      MODE_GLOW: begin
        fs_nxt_a = s_i; fs_nxt_b = s_i; dden_nxt = if_v;
        grd_nxt  = (s_i == 8'd0) || (f_i == FULL);
        gval_nxt = (s_i == 8'd0) ? f_i : FULL;
      end
      default: begin
      end
    endcase
    if (grd_nxt) begin
      dden_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= mode_i;
    s1_r    <= s_i;
    fs1_r   <= f_i * s_i;
    inv1_r  <= if_v * is_v;
    dnum1_r <= fs_nxt_a * fs_nxt_b;
    dden1_r <= dden_nxt;
    grd1_r  <= grd_nxt;
    gval1_r <= gval_nxt;
    simp1_r <= simp_nxt;
  end

  // stage 2: arithmetic modes, first quotient bits
  logic [7:0] arith_nxt, rem_a;
  logic [3:0] qhi_nxt;
  logic       sat_nxt;
  logic [8:0] ta;

  always_comb begin
    unique case (mode1_r)
      MODE_MULTIPLY: arith_nxt = div255({2'b00, fs1_r});
      MODE_OVERLAY:  arith_nxt = (s1_r < OVL_SPLIT) ? div255({1'b0, fs1_r, 1'b0})
                                                    : FULL - div255({1'b0, inv1_r, 1'b0});
      default:       arith_nxt = FULL - div255({2'b00, inv1_r});
    endcase
    sat_nxt = ({1'b0, dnum1_r[15:9]} >= dden1_r);
    rem_a   = {1'b0, dnum1_r[15:9]};
    qhi_nxt = 4'd0;
    for (int i = 8; i >= 5; i--) begin
      ta = {rem_a, dnum1_r[i]};
      if (ta >= {1'b0, dden1_r}) begin
        ta = ta - {1'b0, dden1_r};
        qhi_nxt = {qhi_nxt[2:0], 1'b1};
      end else begin
        qhi_nxt = {qhi_nxt[2:0], 1'b0};
      end
      rem_a = ta[7:0];
    end
  end

  always_ff @(posedge clk) begin
    mode2_r  <= mode1_r;
    dnum2_r  <= dnum1_r;
    dden2_r  <= dden1_r;
    grd2_r   <= grd1_r;
    gval2_r  <= gval1_r;
    simp2_r  <= simp1_r;
    arith2_r <= arith_nxt;
    sat2_r   <= sat_nxt;
    rem2_r   <= rem_a;
    qhi2_r   <= qhi_nxt;
  end

  // stage 3: last quotient bits, saturate, select
  logic [7:0] rem_b, m_nxt;
  logic [4:0] qlo;
  logic [8:0] tb, q;
  logic       over;

  always_comb begin
    rem_b = rem2_r;
    qlo   = 5'd0;
    for (int i = 4; i >= 0; i--) begin
      tb = {rem_b, dnum2_r[i]};
      if (tb >= {1'b0, dden2_r}) begin
        tb = tb - {1'b0, dden2_r};
        qlo = {qlo[3:0], 1'b1};
      end else begin
        qlo = {qlo[3:0], 1'b0};
      end
      rem_b = tb[7:0];
    end
    q    = {qhi2_r, qlo};
    over = sat2_r || q[8];
    unique case (mode2_r)
      MODE_BURN:                          m_nxt = over ? 8'd0 : FULL - q[7:0];
      MODE_DODGE, MODE_REFLECT, MODE_GLOW: m_nxt = over ? FULL : q[7:0];
      MODE_MULTIPLY, MODE_OVERLAY, MODE_SCREEN: m_nxt = arith2_r;
      default:                            m_nxt = simp2_r;
    endcase
    if (grd2_r) begin
      m_nxt = gval2_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  assign m_o = m_r;

endmodule
`default_nettype wire

>>> rtl/core/bld_div.sv
// Pipelined restoring divider: 24 quotient bits, four per stage, six stages.
// Depends on bld_pkg.
`default_nettype none
module bld_div (
  input  wire logic        clk,
  input  wire logic [31:0] num_i,
  input  wire logic [23:0] den_i,
  output logic [23:0]      quo_o
);
  import bld_pkg::*;

  logic [23:0] rem_r [DIV_STAGES];
  logic [23:0] low_r [DIV_STAGES];
  logic [23:0] quo_r [DIV_STAGES];
  logic [23:0] den_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [23:0] rem_in, low_in, quo_in, den_in;
    logic [23:0] rem_nxt, low_nxt, quo_nxt;
    logic [24:0] t;

    if (g == 0) begin : g_first
      assign rem_in = num_i[31:8];
      assign low_in = {num_i[7:0], 16'd0};
      assign quo_in = 24'd0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign low_in = low_r[g-1];
      assign quo_in = quo_r[g-1];
      assign den_in = den_r[g-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      low_nxt = low_in;
      quo_nxt = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        t       = {rem_nxt, low_nxt[23]};
        low_nxt = {low_nxt[22:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          t       = t - {1'b0, den_in};
          quo_nxt = {quo_nxt[22:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[22:0], 1'b0};
        end
        rem_nxt = t[23:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= rem_nxt;
      low_r[g] <= low_nxt;
      quo_r[g] <= quo_nxt;
      den_r[g] <= den_in;
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire
